>>> rtl/hgcd_pkg.sv
// Package for the great-circle distance block: shared constants, types,
// the arctangent table and the rounded Q30 product.
// No dependencies.
package hgcd_pkg;

	localparam int CORDIC_STAGES = 24;
	localparam int STAGES = (CORDIC_STAGES > 32) ? 32 : CORDIC_STAGES;

	typedef logic signed [33:0] cval_t;

	localparam logic [63:0] PI_Q60 = 64'h3243F6A8885A308D;
	localparam logic [63:0] DEG2RAD_Q35 = ((PI_Q60 / 64'd180) + (64'd1 << 24)) >> 25;
	localparam cval_t GAIN_Q30 = 34'sh26DD3B6A;
	localparam cval_t HALF_PI_Q30 = 34'sd1686629713;

	localparam logic signed [30:0] DEG_90 = 31'sd188743680;
	localparam logic signed [30:0] DEG_180 = 31'sd377487360;
	localparam logic signed [30:0] DEG_360 = 31'sd754974720;

	localparam logic [31:0] RADIUS_KM_Q19 = 32'd3340238848;
	localparam logic [63:0] RADIUS_MI_WIDE =
		(64'd3958755864232 * 64'd524288 + 64'd500000000) / 64'd1000000000;
	localparam logic [31:0] RADIUS_MI_Q19 = RADIUS_MI_WIDE[31:0];

	localparam logic UNIT_KM = 1'b0;
	localparam logic UNIT_MI = 1'b1;

	function automatic cval_t atan_q30(input int i);
		cval_t v;
		case (i)
			0: v = 34'sh3243F6A8;
			1: v = 34'sh1DAC6705;
			2: v = 34'sh0FADBAFC;
			3: v = 34'sh07F56EA6;
			4: v = 34'sh03FEAB76;
			5: v = 34'sh01FFD55B;
			6: v = 34'sh00FFFAAA;
			7: v = 34'sh007FFF55;
			8: v = 34'sh003FFFEA;
			9: v = 34'sh001FFFFD;
			10: v = 34'sh000FFFFF;
			11: v = 34'sh0007FFFF;
			12: v = 34'sh0003FFFF;
			13: v = 34'sh0001FFFF;
			14: v = 34'sh0000FFFF;
			15: v = 34'sh00007FFF;
			16: v = 34'sh00003FFF;
			17: v = 34'sh00001FFF;
			18: v = 34'sh00000FFF;
			19: v = 34'sh000007FF;
			20: v = 34'sh000003FF;
			21: v = 34'sh000001FF;
			22: v = 34'sh000000FF;
			23: v = 34'sh0000007F;
			24: v = 34'sh0000003F;
			25: v = 34'sh0000001F;
			26: v = 34'sh0000000F;
			27: v = 34'sh00000008;
			28: v = 34'sh00000004;
			29: v = 34'sh00000002;
			30: v = 34'sh00000001;
			default: v = 34'sh0;
		endcase
		return v;
	endfunction

	// Q30 product, rounded half up on the magnitude.
	function automatic cval_t mul_q30(input cval_t a, input cval_t b);
		logic neg;
		logic [32:0] ua;
		logic [32:0] ub;
		logic [65:0] p;
		cval_t r;
		neg = a[33] ^ b[33];
		ua = a[33] ? 33'(-a) : 33'(a);
		ub = b[33] ? 33'(-b) : 33'(b);
		p = (66'(ua) * 66'(ub) + (66'd1 << 29)) >> 30;
		r = cval_t'(p[33:0]);
		return neg ? -r : r;
	endfunction

endpackage

>>> rtl/hgcd_sincos.sv
// Pipelined sine and cosine of an angle in degrees with 21 fraction bits.
// Range reduction, conversion to radians, then rotation CORDIC stages.
// Depends on hgcd_pkg.
module hgcd_sincos (
	input logic clk,
	input logic arst_n,
	input logic vld_in,
	input logic signed [29:0] deg,
	output logic vld_out,
	output hgcd_pkg::cval_t sin_val,
	output hgcd_pkg::cval_t cos_val
);

	localparam int N = hgcd_pkg::STAGES;

	logic signed [30:0] r0, r1, r2, r3;
	logic fold;
	logic [27:0] mag;

	logic [27:0] mag_s1;
	logic rneg_s1, neg_s1, vld_s1;
	logic [63:0] prod;
	logic [33:0] zmag;

	hgcd_pkg::cval_t cx_s [0:N];
	hgcd_pkg::cval_t cy_s [0:N];
	hgcd_pkg::cval_t cz_s [0:N];
	logic neg_s [0:N];
	logic vld_s [0:N];

	always_comb begin
		r0 = 31'(deg);
		r1 = (r0 < 0) ? r0 + hgcd_pkg::DEG_360 : r0;
		r2 = (r1 >= hgcd_pkg::DEG_180) ? r1 - hgcd_pkg::DEG_360 : r1;
		fold = 1'b0;
		r3 = r2;
		if (r2 > hgcd_pkg::DEG_90) begin
			r3 = r2 - hgcd_pkg::DEG_180;
			fold = 1'b1;
		end else if (r2 < -hgcd_pkg::DEG_90) begin
			r3 = r2 + hgcd_pkg::DEG_180;
			fold = 1'b1;
		end
		mag = r3[30] ? 28'(-r3) : 28'(r3);
	end

	assign prod = 64'(mag_s1) * hgcd_pkg::DEG2RAD_Q35;
	assign zmag = 34'((prod + (64'd1 << 25)) >> 26);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s[0] <= 1'b0;
			vld_out <= 1'b0;
		end else begin
			vld_s1 <= vld_in;
			vld_s[0] <= vld_s1;
			vld_out <= vld_s[N];
		end
	end

	always_ff @(posedge clk) begin
		mag_s1 <= mag;
		rneg_s1 <= r3[30];
		neg_s1 <= fold;
		cx_s[0] <= hgcd_pkg::GAIN_Q30;
		cy_s[0] <= '0;
		cz_s[0] <= rneg_s1 ? -$signed(zmag) : $signed(zmag);
		neg_s[0] <= neg_s1;
		sin_val <= neg_s[N] ? -cy_s[N] : cy_s[N];
		cos_val <= neg_s[N] ? -cx_s[N] : cx_s[N];
	end

	for (genvar i = 0; i < N; i++) begin : g_rot
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else begin
				vld_s[i+1] <= vld_s[i];
			end
		end
		always_ff @(posedge clk) begin
			neg_s[i+1] <= neg_s[i];
			if (!cz_s[i][33]) begin
				cx_s[i+1] <= cx_s[i] - (cy_s[i] >>> i);
				cy_s[i+1] <= cy_s[i] + (cx_s[i] >>> i);
				cz_s[i+1] <= cz_s[i] - hgcd_pkg::atan_q30(i);
			end else begin
				cx_s[i+1] <= cx_s[i] + (cy_s[i] >>> i);
				cy_s[i+1] <= cy_s[i] - (cx_s[i] >>> i);
				cz_s[i+1] <= cz_s[i] + hgcd_pkg::atan_q30(i);
			end
		end
	end

endmodule

>>> rtl/hgcd_sqrt.sv
// Pipelined floor square root of a Q30 value, one result bit per stage.
// The result is again in Q30.
// Does not depend on hgcd_pkg.
module hgcd_sqrt (
	input logic clk,
	input logic arst_n,
	input logic vld_in,
	input logic [30:0] val,
	output logic vld_out,
	output logic [30:0] root
);

	localparam int NB = 31;

	logic [61:0] rem_s [0:NB];
	logic [30:0] q_s [0:NB];
	logic vld_s [0:NB];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else begin
			vld_s[0] <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		rem_s[0] <= {1'b0, val, 30'b0};
		q_s[0] <= '0;
	end

	assign vld_out = vld_s[NB];
	assign root = q_s[NB];

	for (genvar k = 0; k < NB; k++) begin : g_bit
		localparam int B = NB - 1 - k;
		logic [61:0] delta;
		assign delta = (62'(q_s[k]) << (B + 1)) + (62'd1 << (2 * B));
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else begin
				vld_s[k+1] <= vld_s[k];
			end
		end
		always_ff @(posedge clk) begin
			if (rem_s[k] >= delta) begin
				rem_s[k+1] <= rem_s[k] - delta;
				q_s[k+1] <= q_s[k] | (31'd1 << B);
			end else begin
				rem_s[k+1] <= rem_s[k];
				q_s[k+1] <= q_s[k];
			end
		end
	end

endmodule

>>> rtl/hgcd_atan.sv
// Pipelined vectoring CORDIC giving twice atan2(y, x) for non-negative
// Q30 inputs, clamped to the range 0 to pi.
// Depends on hgcd_pkg.
module hgcd_atan (
	input logic clk,
	input logic arst_n,
	input logic vld_in,
	input logic [30:0] y_in,
	input logic [30:0] x_in,
	output logic vld_out,
	output logic [31:0] angle
);

	localparam int N = hgcd_pkg::STAGES;

	hgcd_pkg::cval_t vx_s [0:N];
	hgcd_pkg::cval_t vy_s [0:N];
	hgcd_pkg::cval_t vz_s [0:N];
	logic vld_s [0:N];
	hgcd_pkg::cval_t zc;

	always_comb begin
		zc = vz_s[N];
		if (zc < 0) begin
			zc = '0;
		end else if (zc > hgcd_pkg::HALF_PI_Q30) begin
			zc = hgcd_pkg::HALF_PI_Q30;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
			vld_out <= 1'b0;
		end else begin
			vld_s[0] <= vld_in;
			vld_out <= vld_s[N];
		end
	end

	always_ff @(posedge clk) begin
		vx_s[0] <= $signed(34'(x_in));
		vy_s[0] <= $signed(34'(y_in));
		vz_s[0] <= '0;
		angle <= {zc[30:0], 1'b0};
	end

	for (genvar i = 0; i < N; i++) begin : g_vec
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else begin
				vld_s[i+1] <= vld_s[i];
			end
		end
		always_ff @(posedge clk) begin
			if (vy_s[i] > 0) begin
				vx_s[i+1] <= vx_s[i] + (vy_s[i] >>> i);
				vy_s[i+1] <= vy_s[i] - (vx_s[i] >>> i);
				vz_s[i+1] <= vz_s[i] + hgcd_pkg::atan_q30(i);
			end else begin
				vx_s[i+1] <= vx_s[i] - (vy_s[i] >>> i);
				vy_s[i+1] <= vy_s[i] + (vx_s[i] >>> i);
				vz_s[i+1] <= vz_s[i] - hgcd_pkg::atan_q30(i);
			end
		end
	end

endmodule

>>> rtl/haversine_great_circle_distance.sv
// Top level of the haversine great-circle distance pipeline.
// Depends on hgcd_pkg, hgcd_sincos, hgcd_sqrt and hgcd_atan.
//
//   channel   handshake              words carried
//   -------   --------------------   ---------------------------------------
//   input     start (busy low)       first/second latitude and longitude
//   result    done strobe            central_angle, distance
//   config    cfg_valid, cfg_ready   cfg_data (distance unit)
//
// One word is taken in every cycle; busy stays low. The path of a result runs
// through the two CORDIC pipelines and the 31-stage square root. Reset clears
// only the valid bits and the unit register (kilometres). The receiver cannot
// stall, so nothing waits.
module haversine_great_circle_distance (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic cfg_data,
	input logic signed [27:0] first_latitude,
	input logic signed [28:0] first_longitude,
	input logic signed [27:0] second_latitude,
	input logic signed [28:0] second_longitude,
	output logic done,
	output logic [31:0] central_angle,
	output logic [30:0] distance
);

	logic unit_q;
	logic vld_s1;
	logic signed [29:0] dlat_s1, dlon_s1, lat1_s1, lat2_s1;
	logic v_lat, v_lon, v_c1, v_c2;
	hgcd_pkg::cval_t s_lat, s_lon, c1, c2, unused_a, unused_b, unused_c, unused_d;

	hgcd_pkg::cval_t sq_lat_s2, sq_lon_s2, cc_s2, sq_lat_s3, t_s3;
	logic vld_s2, vld_s3, vld_s4;
	logic signed [34:0] a_sum;
	logic [30:0] a_s4, b_s4;
	logic v_ra, v_rb, v_ang;
	logic [30:0] root_a, root_b;
	logic [31:0] angle;
	logic [31:0] radius;
	logic [63:0] dist_wide;

	assign busy = 1'b0;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			unit_q <= hgcd_pkg::UNIT_KM;
		end else if (cfg_valid) begin
			unit_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			done <= 1'b0;
		end else begin
			vld_s1 <= start;
			vld_s2 <= v_lat;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			done <= v_ang;
		end
	end

	always_ff @(posedge clk) begin
		dlat_s1 <= 30'(second_latitude) - 30'(first_latitude);
		dlon_s1 <= 30'(second_longitude) - 30'(first_longitude);
		lat1_s1 <= 30'(first_latitude) <<< 1;
		lat2_s1 <= 30'(second_latitude) <<< 1;
	end

	hgcd_sincos u_lat (.clk(clk), .arst_n(arst_n), .vld_in(vld_s1), .deg(dlat_s1),
		.vld_out(v_lat), .sin_val(s_lat), .cos_val(unused_a));
	hgcd_sincos u_lon (.clk(clk), .arst_n(arst_n), .vld_in(vld_s1), .deg(dlon_s1),
		.vld_out(v_lon), .sin_val(s_lon), .cos_val(unused_b));
	hgcd_sincos u_c1 (.clk(clk), .arst_n(arst_n), .vld_in(vld_s1), .deg(lat1_s1),
		.vld_out(v_c1), .sin_val(unused_c), .cos_val(c1));
	hgcd_sincos u_c2 (.clk(clk), .arst_n(arst_n), .vld_in(vld_s1), .deg(lat2_s1),
		.vld_out(v_c2), .sin_val(unused_d), .cos_val(c2));

	always_comb begin
		a_sum = 35'(sq_lat_s3) + 35'(t_s3);
		if (a_sum < 0) begin
			a_sum = '0;
		end else if (a_sum > (35'sd1 <<< 30)) begin
			a_sum = 35'sd1 <<< 30;
		end
	end

	always_ff @(posedge clk) begin
		sq_lat_s2 <= hgcd_pkg::mul_q30(s_lat, s_lat);
		sq_lon_s2 <= hgcd_pkg::mul_q30(s_lon, s_lon);
		cc_s2 <= hgcd_pkg::mul_q30(c1, c2);
		sq_lat_s3 <= sq_lat_s2;
		t_s3 <= hgcd_pkg::mul_q30(cc_s2, sq_lon_s2);
		a_s4 <= a_sum[30:0];
		b_s4 <= (31'd1 << 30) - a_sum[30:0];
	end

	hgcd_sqrt u_ra (.clk(clk), .arst_n(arst_n), .vld_in(vld_s4), .val(a_s4),
		.vld_out(v_ra), .root(root_a));
	hgcd_sqrt u_rb (.clk(clk), .arst_n(arst_n), .vld_in(vld_s4), .val(b_s4),
		.vld_out(v_rb), .root(root_b));

	hgcd_atan u_atan (.clk(clk), .arst_n(arst_n), .vld_in(v_ra & v_rb & v_lon & v_c1 & v_c2
		| v_ra), .y_in(root_a), .x_in(root_b), .vld_out(v_ang), .angle(angle));

	assign radius = (unit_q == hgcd_pkg::UNIT_MI) ? hgcd_pkg::RADIUS_MI_Q19
		: hgcd_pkg::RADIUS_KM_Q19;
	assign dist_wide = 64'(angle) * 64'(radius);

	always_ff @(posedge clk) begin
		central_angle <= angle;
		distance <= 31'((dist_wide + (64'd1 << 32)) >> 33);
	end

endmodule

>>> test/hgcd_checker.sv
// Checker for the great-circle distance block: watches the input, result and
// configuration channels, predicts each result and compares it field by field.
// Depends on hgcd_pkg for the stage count, table and constants.
`timescale 1ns / 100ps

module hgcd_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic cfg_valid,
	input logic cfg_ready,
	input logic cfg_data,
	input logic signed [27:0] first_latitude,
	input logic signed [28:0] first_longitude,
	input logic signed [27:0] second_latitude,
	input logic signed [28:0] second_longitude,
	input logic done,
	input logic [31:0] central_angle,
	input logic [30:0] distance,
	output int errors,
	output int pending
);

	typedef struct {
		logic [31:0] angle;
		logic [30:0] dist_q16;
	} span_t;

	span_t span_q[$];
	logic unit_sel;

	assign pending = span_q.size();

	function automatic void trig_q30(input longint deg, output longint s, output longint c);
		longint r;
		longint x;
		longint y;
		longint z;
		longint t;
		longint unsigned mag;
		bit flip;
		bit rneg;
		r = deg % longint'(hgcd_pkg::DEG_360);
		flip = 0;
		x = longint'(hgcd_pkg::GAIN_Q30);
		y = 0;
		if (r < 0) r += longint'(hgcd_pkg::DEG_360);
		if (r >= longint'(hgcd_pkg::DEG_180)) r -= longint'(hgcd_pkg::DEG_360);
		if (r > longint'(hgcd_pkg::DEG_90)) begin
			r -= longint'(hgcd_pkg::DEG_180);
			flip = 1;
		end else if (r < -longint'(hgcd_pkg::DEG_90)) begin
			r += longint'(hgcd_pkg::DEG_180);
			flip = 1;
		end
		rneg = r < 0;
		mag = rneg ? longint'(-r) : r;
		mag = (mag * hgcd_pkg::DEG2RAD_Q35 + (64'd1 << 25)) >> 26;
		z = rneg ? -longint'(mag) : longint'(mag);
		for (int i = 0; i < hgcd_pkg::STAGES; i++) begin
			if (z >= 0) begin
				t = x - (y >>> i);
				y = y + (x >>> i);
				z -= longint'(hgcd_pkg::atan_q30(i));
			end else begin
				t = x + (y >>> i);
				y = y - (x >>> i);
				z += longint'(hgcd_pkg::atan_q30(i));
			end
			x = t;
		end
		s = flip ? -y : y;
		c = flip ? -x : x;
	endfunction

	function automatic longint vector_angle(input longint yy, input longint xx);
		longint x;
		longint y;
		longint z;
		longint t;
		x = xx;
		y = yy;
		z = 0;
		for (int i = 0; i < hgcd_pkg::STAGES; i++) begin
			if (y > 0) begin
				t = x + (y >>> i);
				y = y - (x >>> i);
				z += longint'(hgcd_pkg::atan_q30(i));
			end else begin
				t = x - (y >>> i);
				y = y + (x >>> i);
				z -= longint'(hgcd_pkg::atan_q30(i));
			end
			x = t;
		end
		if (z < 0) z = 0;
		if (z > longint'(hgcd_pkg::HALF_PI_Q30)) z = longint'(hgcd_pkg::HALF_PI_Q30);
		return z;
	endfunction

	function automatic longint rmul_q30(input longint a, input longint b);
		longint unsigned ua;
		longint unsigned ub;
		longint r;
		ua = (a < 0) ? longint'(-a) : a;
		ub = (b < 0) ? longint'(-b) : b;
		r = longint'((ua * ub + (64'd1 << 29)) >> 30);
		return ((a < 0) != (b < 0)) ? -r : r;
	endfunction

	function automatic longint unsigned isqrt64(input longint unsigned v);
		longint unsigned r;
		longint unsigned b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic span_t predict_span(input longint lat1, input longint lon1,
		input longint lat2, input longint lon2, input logic mi);
		longint s_lat;
		longint s_lon;
		longint c1;
		longint c2;
		longint unused;
		longint a;
		longint unsigned ang;
		longint unsigned rad;
		span_t res;
		trig_q30(lat2 - lat1, s_lat, unused);
		trig_q30(lon2 - lon1, s_lon, unused);
		trig_q30(lat1 * 2, unused, c1);
		trig_q30(lat2 * 2, unused, c2);
		a = rmul_q30(s_lat, s_lat) + rmul_q30(rmul_q30(c1, c2), rmul_q30(s_lon, s_lon));
		if (a < 0) a = 0;
		if (a > (longint'(1) << 30)) a = longint'(1) << 30;
		ang = 2 * vector_angle(longint'(isqrt64(a << 30)),
			longint'(isqrt64(((longint'(1) << 30) - a) << 30)));
		if (ang > 64'd3373259426) ang = 64'd3373259426;
		rad = (mi == hgcd_pkg::UNIT_MI) ? 64'(hgcd_pkg::RADIUS_MI_Q19)
			: 64'(hgcd_pkg::RADIUS_KM_Q19);
		res.angle = ang[31:0];
		res.dist_q16 = 31'((ang * rad + (64'd1 << 32)) >> 33);
		return res;
	endfunction

	task automatic report_mismatch(input string what);
		$display("[%0t] mismatch: %s", $time, what);
		errors++;
	endtask

	initial errors = 0;

	always @(posedge clk or negedge arst_n) begin
		span_t got;
		span_t want;
		if (!arst_n) begin
			unit_sel <= hgcd_pkg::UNIT_KM;
			span_q.delete();
		end else begin
			if (cfg_valid && cfg_ready) unit_sel <= cfg_data;
			if (start && !busy)
				span_q.push_back(predict_span(first_latitude, first_longitude,
					second_latitude, second_longitude, unit_sel));
			if (done) begin
				if (span_q.size() == 0) begin
					report_mismatch("result word with nothing expected");
				end else begin
					want = span_q.pop_front();
					got.angle = central_angle;
					got.dist_q16 = distance;
					if (got.angle !== want.angle)
						report_mismatch($sformatf("central_angle %0d, expected %0d",
							got.angle, want.angle));
					if (got.dist_q16 !== want.dist_q16)
						report_mismatch($sformatf("distance %0d, expected %0d",
							got.dist_q16, want.dist_q16));
				end
			end
		end
	end

endmodule

>>> test/tb_haversine_great_circle_distance.sv
// Testbench top for the great-circle distance block: drives point pairs and
// unit settings, mostly with random gaps; hgcd_checker predicts and compares.
// Depends on hgcd_pkg, the block and hgcd_checker.
`timescale 1ns / 100ps

module tb_haversine_great_circle_distance;

	localparam int LAT_MAX = 94371840;
	localparam int LON_MAX = 188743680;
	localparam int STALL_LIMIT = 5000;

	logic clk = 0;
	logic arst_n = 0;
	logic start = 0;
	logic busy;
	logic cfg_valid = 0;
	logic cfg_ready;
	logic cfg_data = 0;
	logic signed [27:0] first_latitude = 0;
	logic signed [28:0] first_longitude = 0;
	logic signed [27:0] second_latitude = 0;
	logic signed [28:0] second_longitude = 0;
	logic done;
	logic [31:0] central_angle;
	logic [30:0] distance;
	int errors;
	int pending;
	int stall_cycles = 0;
	bit gaps_on = 1;

	always #10 clk = ~clk;

	haversine_great_circle_distance dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.first_latitude(first_latitude), .first_longitude(first_longitude),
		.second_latitude(second_latitude), .second_longitude(second_longitude),
		.done(done), .central_angle(central_angle), .distance(distance)
	);

	hgcd_checker checker_i (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.first_latitude(first_latitude), .first_longitude(first_longitude),
		.second_latitude(second_latitude), .second_longitude(second_longitude),
		.done(done), .central_angle(central_angle), .distance(distance),
		.errors(errors), .pending(pending)
	);

	always @(posedge clk) begin
		if ((start && !busy) || done || (cfg_valid && cfg_ready) || !arst_n)
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	task automatic send_pair(input int lat1, input int lon1, input int lat2, input int lon2);
		logic held;
		while (gaps_on && $urandom_range(99) < 27) begin
			start <= 0;
			@(posedge clk);
		end
		start <= 1;
		first_latitude <= 28'(lat1);
		first_longitude <= 29'(lon1);
		second_latitude <= 28'(lat2);
		second_longitude <= 29'(lon2);
		do begin
			@(negedge clk);
			held = busy;
			@(posedge clk);
		end while (held);
	endtask

	task automatic drain_results();
		start <= 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	task automatic write_unit(input logic u);
		logic held;
		drain_results();
		cfg_valid <= 1;
		cfg_data <= u;
		do begin
			@(negedge clk);
			held = !cfg_ready;
			@(posedge clk);
		end while (held);
		cfg_valid <= 0;
	endtask

	function automatic int any_lat();
		return int'($signed(28'($urandom)));
	endfunction

	function automatic int any_lon();
		return int'($signed(29'($urandom)));
	endfunction

	task automatic random_pairs(input int n);
		int lat1;
		int lat2;
		for (int k = 0; k < n; k++) begin
			if ($urandom_range(99) < 80) begin
				lat1 = int'($urandom_range(2 * LAT_MAX)) - LAT_MAX;
				// Close latitudes exercise a small latitude difference.
				if ($urandom_range(3) == 0)
					lat2 = lat1 + int'($urandom_range(2000)) - 1000;
				else
					lat2 = int'($urandom_range(2 * LAT_MAX)) - LAT_MAX;
				send_pair(lat1, int'($urandom_range(2 * LON_MAX)) - LON_MAX,
					lat2, int'($urandom_range(2 * LON_MAX)) - LON_MAX);
			end else begin
				send_pair(any_lat(), any_lon(), any_lat(), any_lon());
			end
		end
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		send_pair(0, 0, 0, 0);
		send_pair(LAT_MAX, 0, -LAT_MAX, 0);
		send_pair(0, -LON_MAX, 0, LON_MAX);
		send_pair(0, 0, 0, LON_MAX);
		send_pair(0, 0, 0, LON_MAX / 2);
		send_pair(LAT_MAX, LON_MAX, LAT_MAX, -LON_MAX);
		send_pair(-LAT_MAX, 12345, LAT_MAX, -54321);
		send_pair(1 << 20, 1 << 20, 1 << 20, 1 << 20);
		send_pair(0, 0, 1, 1);
		send_pair(-(1 << 27), -(1 << 28), (1 << 27) - 1, (1 << 28) - 1);
		send_pair((1 << 27) - 1, (1 << 28) - 1, -(1 << 27), -(1 << 28));
		send_pair(100 << 20, 0, 80 << 20, 0);
		send_pair(-(120 << 20), 200 << 20, 45 << 20, -(250 << 20));
		send_pair(30 << 20, 10 << 20, -(30 << 20), -(170 << 20));
		send_pair(51 << 20, 0, 40 << 20, -(74 << 20));
		send_pair(-(1 << 27), 0, -(1 << 27), 0);
		write_unit(hgcd_pkg::UNIT_MI);
		send_pair(0, 0, 0, LON_MAX);
		send_pair(51 << 20, 0, 40 << 20, -(74 << 20));
		send_pair(LAT_MAX, 0, -LAT_MAX, 0);
		random_pairs(430);

		write_unit(hgcd_pkg::UNIT_KM);
		random_pairs(150);
		gaps_on = 0;
		random_pairs(200);
		gaps_on = 1;
		drain_results();
		random_pairs(100);

		write_unit(hgcd_pkg::UNIT_MI);
		random_pairs(450);

		drain_results();
		repeat (120) @(posedge clk);
		if (errors == 0 && pending == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
